// ----- hdl/multiswitch_pulse_frame_encoder_top_defines.svh -----
// Assertion macros used by the checker module.
`ifndef MULTISWITCH_PULSE_FRAME_ENCODER_TOP_DEFINES_SVH
`define MULTISWITCH_PULSE_FRAME_ENCODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPFE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mpfe_pkg.sv -----
`timescale 1ns / 1ps

package mpfe_pkg;

    localparam int WORD_W  = 16;
    localparam int PULSE_W = 12;
    localparam int POS_W   = 5;
    localparam int MODE_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_SW16   = 3'd0,
        MODE_SW12P2 = 3'd1,
        MODE_SW8    = 3'd2,
        MODE_PAIR8  = 3'd3,
        MODE_DSYNC  = 3'd4,
        MODE_NONE   = 3'd5
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE      = 3'd0,
        CFG_P0_STOP   = 3'd1,
        CFG_P0_FWD    = 3'd2,
        CFG_P0_REAR   = 3'd3,
        CFG_P1_STOP   = 3'd4,
        CFG_P1_FWD    = 3'd5,
        CFG_P1_REAR   = 3'd6
    } cfg_index_t;

    localparam logic [PULSE_W-1:0] US_SYNC      = 12'd950;
    localparam logic [PULSE_W-1:0] US_SW_ON     = 12'd1250;
    localparam logic [PULSE_W-1:0] US_SW_OFF    = 12'd1750;
    localparam logic [PULSE_W-1:0] US_NEUTRAL   = 12'd1500;
    localparam logic [PULSE_W-1:0] US_PAIR_LO   = 12'd1100;
    localparam logic [PULSE_W-1:0] US_PAIR_MID  = 12'd1300;
    localparam logic [PULSE_W-1:0] US_PAIR_HI   = 12'd1500;
    localparam logic [PULSE_W-1:0] US_PAIR_OFS  = 12'd600;
    localparam logic [PULSE_W-1:0] US_DSYNC     = 12'd2100;
    localparam logic [PULSE_W-1:0] US_DS_BOTTOM = 12'd1900;
    localparam logic [PULSE_W-1:0] US_DS_TOP    = 12'd1150;

endpackage

// ----- hdl/multiswitch_pulse_frame_encoder_top.sv -----
// Multi-switch pulse frame encoder.
// The s_axis channel takes one word per servo frame slot: s_axis_tdata holds the
// 16-bit switch word. The m_axis channel returns one word per input word with the
// pulse width in microseconds for that slot in m_axis_tdata bits 11..0.
// The cfg channel writes the mode (index 0) and the six proportional widths
// (indexes 1 to 6); cfg_ready is always high and other indexes are ignored.
// A mode write restarts the frame at the first slot. Configure only while idle.
// A word accepted on s_axis is registered and offered on m_axis in the next cycle.
// One word per cycle while m_axis is not stalled; the slot position update and
// width select are a single small block of logic in front of the output register.
// While the receiver stalls, the output register holds its word and s_axis_tready
// stays high only if the output register will be emptied in the same cycle.
// Reset clears the slot position, sets the mode to none and every proportional
// width to 1500, and empties the output register.
`timescale 1ns / 1ps

module multiswitch_pulse_frame_encoder_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // switch_word [15:0]
    input  logic [mpfe_pkg::WORD_W-1:0]         s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pulse_width_us [11:0], zero [15:12]
    output logic [mpfe_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mpfe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mpfe_pkg::PULSE_W-1:0]        cfg_data
);
    import mpfe_pkg::*;

    logic [MODE_W-1:0]  mode_reg;
    logic [PULSE_W-1:0] p0_stop_reg, p0_fwd_reg, p0_rear_reg;
    logic [PULSE_W-1:0] p1_stop_reg, p1_fwd_reg, p1_rear_reg;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               out_valid_reg;
    logic [PULSE_W-1:0] out_data_reg, width_next;

    logic               in_accept, cfg_accept;
    logic [POS_W-1:0]   last_slot, sw_pos, ds_pos_inc;
    logic [3:0]         idx_a, idx_b;
    logic               bit_a, bit_b;
    logic [3:0]         pair_slot;
    logic [PULSE_W-1:0] pair_base;

    function automatic logic [PULSE_W-1:0] prop_pick(
        input logic [PULSE_W-1:0] stop_us,
        input logic [PULSE_W-1:0] fwd_us,
        input logic [PULSE_W-1:0] rear_us,
        input logic               fwd,
        input logic               rear
    );
        logic [PULSE_W-1:0] res;
        if (fwd == rear)
        begin
            res = stop_us;
        end
        else if (fwd)
        begin
            res = fwd_us;
        end
        else
        begin
            res = rear_us;
        end
        return res;
    endfunction

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign cfg_accept    = cfg_valid && cfg_ready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-PULSE_W){1'b0}}, out_data_reg};

    assign pair_slot  = pos_reg[POS_W-1:1];
    assign ds_pos_inc = pos_reg + 5'd1;

    always_comb
    begin
        width_next = US_NEUTRAL;
        pos_next   = pos_reg;
        last_slot  = 5'd8;
        sw_pos     = pos_reg;
        idx_a      = pos_reg[3:0];
        idx_b      = 4'(pos_reg[3:0] + 4'd1);
        bit_a      = 1'b0;
        bit_b      = 1'b0;
        pair_base  = US_PAIR_MID;
        case (mode_reg)
            MODE_SW16, MODE_SW12P2, MODE_SW8:
            begin
                if (mode_reg == MODE_SW16)
                begin
                    last_slot = 5'd16;
                end
                else if (mode_reg == MODE_SW12P2)
                begin
                    last_slot = 5'd14;
                end
                sw_pos   = (pos_reg != 5'd0) ? pos_reg - 5'd1 : last_slot;
                pos_next = sw_pos;
                if (sw_pos[4])
                begin
                    idx_a = 4'(sw_pos[3:0]);
                end
                if (mode_reg == MODE_SW8)
                begin
                    idx_a = 4'(sw_pos[3:0] + 4'd8);
                end
                else
                begin
                    idx_a = sw_pos[3:0];
                end
                bit_a = s_axis_tdata[idx_a];
                if (sw_pos == last_slot)
                begin
                    width_next = US_SYNC;
                end
                else if (mode_reg == MODE_SW12P2 && sw_pos >= 5'd12)
                begin
                    if (sw_pos > 5'd12)
                    begin
                        width_next = prop_pick(p1_stop_reg, p1_fwd_reg, p1_rear_reg,
                                               s_axis_tdata[15], s_axis_tdata[14]);
                    end
                    else
                    begin
                        width_next = prop_pick(p0_stop_reg, p0_fwd_reg, p0_rear_reg,
                                               s_axis_tdata[13], s_axis_tdata[12]);
                    end
                end
                else
                begin
                    width_next = bit_a ? US_SW_ON : US_SW_OFF;
                end
            end
            MODE_PAIR8:
            begin
                bit_a = s_axis_tdata[idx_a];
                bit_b = s_axis_tdata[idx_b];
                if (bit_a == bit_b)
                begin
                    pair_base = US_PAIR_MID;
                end
                else if (bit_a)
                begin
                    pair_base = US_PAIR_LO;
                end
                else
                begin
                    pair_base = US_PAIR_HI;
                end
                if (pair_slot > 4'd6)
                begin
                    width_next = prop_pick(p1_stop_reg, p1_fwd_reg, p1_rear_reg, bit_b, bit_a);
                end
                else if (pair_slot == 4'd6)
                begin
                    width_next = prop_pick(p0_stop_reg, p0_fwd_reg, p0_rear_reg, bit_b, bit_a);
                end
                else if (pair_slot < 4'd4)
                begin
                    width_next = pair_base + US_PAIR_OFS;
                end
                else
                begin
                    width_next = pair_base;
                end
                pos_next = (pair_slot >= 4'd7) ? 5'd0 : pos_reg + 5'd2;
            end
            MODE_DSYNC:
            begin
                idx_a = 4'({pos_reg[2:0], 1'b0} - 4'd4);
                idx_b = 4'(idx_a + 4'd1);
                bit_a = s_axis_tdata[idx_a];
                bit_b = s_axis_tdata[idx_b];
                if (pos_reg < 5'd2)
                begin
                    width_next = US_DSYNC;
                end
                else if (bit_a == bit_b)
                begin
                    width_next = US_NEUTRAL;
                end
                else if (bit_b)
                begin
                    width_next = US_DS_BOTTOM;
                end
                else
                begin
                    width_next = US_DS_TOP;
                end
                pos_next = (ds_pos_inc >= 5'd10) ? 5'd0 : ds_pos_inc;
            end
            default:
            begin
                width_next = US_NEUTRAL;
                pos_next   = pos_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NONE;
            p0_stop_reg <= US_NEUTRAL;
            p0_fwd_reg  <= US_NEUTRAL;
            p0_rear_reg <= US_NEUTRAL;
            p1_stop_reg <= US_NEUTRAL;
            p1_fwd_reg  <= US_NEUTRAL;
            p1_rear_reg <= US_NEUTRAL;
            pos_reg     <= '0;
        end
        else if (cfg_accept)
        begin
            case (cfg_index)
                CFG_MODE:
                begin
                    mode_reg <= cfg_data[MODE_W-1:0];
                    pos_reg  <= '0;
                end
                CFG_P0_STOP: p0_stop_reg <= cfg_data;
                CFG_P0_FWD:  p0_fwd_reg  <= cfg_data;
                CFG_P0_REAR: p0_rear_reg <= cfg_data;
                CFG_P1_STOP: p1_stop_reg <= cfg_data;
                CFG_P1_FWD:  p1_fwd_reg  <= cfg_data;
                CFG_P1_REAR: p1_rear_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
        else if (in_accept)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= width_next;
        end
    end

endmodule

// ----- hdl/mpfe_checker.sv -----
`timescale 1ns / 1ps
`include "multiswitch_pulse_frame_encoder_top_defines.svh"

module mpfe_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [mpfe_pkg::WORD_W-1:0]      s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [mpfe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [mpfe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [mpfe_pkg::PULSE_W-1:0]     cfg_data
);
    import mpfe_pkg::*;

    `MPFE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "Stalled output word changed or dropped")
    `MPFE_ASSERT_NEXT(a_accept_gives_word, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "Accepted input word gave no output word")
    `MPFE_ASSERT_SAME(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "Input stalled while output register is empty")
    `MPFE_ASSERT_SAME(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:PULSE_W] == '0, "Output padding bits are not zero")

endmodule

bind multiswitch_pulse_frame_encoder_top mpfe_checker u_mpfe_checker (.*);
